/* hdl/avhc_pkg.sv */
// shared constants and types for the arc voltage height controller
`timescale 1ns / 1ps
`default_nettype none

package avhc_pkg;

  // event codes on the request channel
  localparam int OP_W = 2;
  typedef logic [OP_W-1:0] op_code_t;
  localparam op_code_t OP_SAMPLE = 2'd0;
  localparam op_code_t OP_START  = 2'd1;
  localparam op_code_t OP_PROBE  = 2'd2;
  localparam op_code_t OP_STOP   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t REG_WELD_MODE     = 3'd0;
  localparam cfg_index_t REG_HEIGHT_ENABLE = 3'd1;
  localparam cfg_index_t REG_CONTACT_THR   = 3'd2;
  localparam cfg_index_t REG_LEARN_SAMPLES = 3'd3;
  localparam cfg_index_t REG_WINDOW_ABOVE  = 3'd4;
  localparam cfg_index_t REG_WINDOW_BELOW  = 3'd5;
  localparam cfg_index_t REG_HEIGHT_GAIN   = 3'd6;

  // weld modes
  localparam int MODE_W = 2;
  typedef logic [MODE_W-1:0] weld_mode_t;
  localparam weld_mode_t MODE_OFF   = 2'd0;
  localparam weld_mode_t MODE_PULSE = 2'd1;

  // gain and correction formats
  localparam int GAIN_W  = 16;
  localparam int STEPS_W = 16;
  typedef logic signed [STEPS_W-1:0] steps_t;
  localparam int GAIN_FRAC    = 16;
  localparam int STEP_POS_MAX = 32767;
  localparam int STEP_NEG_MAX = 32768;

  // voltage format, Q8.8
  localparam int FRAC_BITS = 8;
  localparam int ONE_VOLT  = 256;
  localparam int HALF_LSB  = 128;

  // count+1 must reach this before corrections are issued
  localparam int CORR_MIN_K = 3;

  // reset values of the configuration registers
  localparam int RST_CONTACT = 256;
  localparam int RST_LEARN   = 16;
  localparam int RST_WINDOW  = 512;
  localparam logic [GAIN_W-1:0] RST_GAIN = 16'd256;

endpackage

`default_nettype wire

/* hdl/avhc_in_if.sv */
// request channel carrying one event per item
`timescale 1ns / 1ps
`default_nettype none

interface avhc_in_if import avhc_pkg::*; #(
  parameter int VOLTAGE_WIDTH = 16
) ();
  logic                     valid;
  logic                     ready;
  op_code_t                 op;
  logic [VOLTAGE_WIDTH-1:0] voltage;
  logic [VOLTAGE_WIDTH-1:0] stored_target;
  logic                     long_move;

  modport source (output valid, output op, output voltage, output stored_target,
                  output long_move, input ready);
  modport sink (input valid, input op, input voltage, input stored_target,
                input long_move, output ready);
endinterface

`default_nettype wire

/* hdl/avhc_out_if.sv */
// result channel carrying one status and correction item per request
`timescale 1ns / 1ps
`default_nettype none

interface avhc_out_if import avhc_pkg::*; #(
  parameter int VOLTAGE_WIDTH = 16
) ();
  logic                     valid;
  logic                     ready;
  logic                     arc_present;
  logic                     short_stop;
  logic                     probe_contact;
  logic                     move_valid;
  steps_t                   move_steps;
  logic                     target_learned;
  logic [VOLTAGE_WIDTH-1:0] target_now;

  modport source (output valid, output arc_present, output short_stop,
                  output probe_contact, output move_valid, output move_steps,
                  output target_learned, output target_now, input ready);
  modport sink (input valid, input arc_present, input short_stop,
                input probe_contact, input move_valid, input move_steps,
                input target_learned, input target_now, output ready);
endinterface

`default_nettype wire

/* hdl/avhc_mul.sv */
// shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module avhc_mul #(
  parameter int A_W = 24,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic               busy,
  output logic [A_W+B_W-1:0] product
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   a_reg;
  logic [A_W-1:0]   hi;
  logic [B_W-1:0]   lo;
  logic [CNT_W-1:0] cnt;
  logic [A_W:0]     sum;

  assign sum     = {1'b0, hi} + (lo[0] ? {1'b0, a_reg} : {(A_W+1){1'b0}});
  assign busy    = (cnt != '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(B_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // multiplier bits leave at the bottom while product bits come in at the top
  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[A_W:1];
      lo <= {sum[0], lo[B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

/* hdl/avhc_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module avhc_div #(
  parameter int Q_W = 24,
  parameter int D_W = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [Q_W+D_W-1:0] num,
  input  logic [D_W-1:0]     den,
  output logic               busy,
  output logic [Q_W-1:0]     quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W-1:0]   rem;
  logic [Q_W-1:0]   q;
  logic [D_W-1:0]   den_reg;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             fits;

  // caller guarantees the top part of num is below den, so the quotient fits Q_W bits
  assign trial = {rem, q[Q_W-1]};
  assign diff  = trial - {1'b0, den_reg};
  assign fits  = (trial >= {1'b0, den_reg});
  assign busy  = (cnt != '0);
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(Q_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= num[Q_W+D_W-1:Q_W];
      q       <= num[Q_W-1:0];
      den_reg <= den;
    end else if (busy) begin
      rem <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
      q   <= {q[Q_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* hdl/arc_voltage_height_control_core.sv */
// Arc voltage height controller: event in, status and height correction out.
// item: one event per request (sample, start weld, begin probe, stop weld) with
//   voltage, stored target and long-move flag. result: one item per request with
//   arc/stop/probe flags, a saturated step correction and the current target.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data; the user
//   must write them only while no request is in flight, which the block does not
//   enforce; writes to unknown indexes are dropped.
// Timing: one request at a time. Events and samples that need no arithmetic go from
//   accept through S_DONE to the result register. A height correction runs the
//   shift-add multiplier; a mean update runs the same multiplier for c*mean and then
//   the restoring divider.
// A finished result sits in an output register; the next request is accepted
//   while it waits, and its result is held back until the receiver takes the old one.
// Reset: synchronous, clears weld and probe state, the learned target, the sample
//   counter, the mean and all configuration registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module arc_voltage_height_control_core import avhc_pkg::*; #(
  parameter int VOLTAGE_WIDTH = 16,
  parameter int COUNT_WIDTH   = 16,
  localparam int CFG_W = (VOLTAGE_WIDTH > COUNT_WIDTH)
                         ? ((VOLTAGE_WIDTH > GAIN_W) ? VOLTAGE_WIDTH : GAIN_W)
                         : ((COUNT_WIDTH > GAIN_W) ? COUNT_WIDTH : GAIN_W)
) (
  input  logic             clk,
  input  logic             rst,
  avhc_in_if.sink          item,
  avhc_out_if.source       result,
  input  logic             cfg_wr_en,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int VW     = VOLTAGE_WIDTH;
  localparam int CW     = COUNT_WIDTH;
  localparam int MEAN_W = VW + 8;
  localparam int K_W    = CW + 1;
  localparam int MB_W   = (CW > GAIN_W) ? CW : GAIN_W;
  localparam int EXT_W  = VW + 2;
  localparam int CMP_W  = VW + 3;
  localparam int NUM_W  = MEAN_W + K_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CMUL = 3'd1;
  localparam logic [2:0] S_MMUL = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  // configuration
  weld_mode_t        weld_mode;
  logic              height_enable;
  logic [EXT_W-1:0]  contact_threshold;
  logic [K_W-1:0]    learn_samples;
  logic [EXT_W-1:0]  window_above;
  logic [EXT_W-1:0]  window_below;
  logic [GAIN_W-1:0] height_gain;

  // controller state; k is the sample count plus one
  logic              welding;
  logic              probing;
  logic [K_W-1:0]    k;
  logic [MEAN_W-1:0] mean;
  logic [VW-1:0]     target;
  logic [2:0]        state;

  // held across the serial steps of one request
  logic              mean_pend;
  logic              corr_neg;
  logic [CW-1:0]     c_hold;
  logic [VW-1:0]     v_hold;
  logic              res_arc;
  logic              res_sstop;
  logic              res_pcont;
  logic              res_mvalid;
  steps_t            res_steps;
  logic              res_learned;
  logic [VW-1:0]     res_target;

  // request decode
  logic              accept;
  logic              height_on;
  logic              sample_live;
  logic              is_contact;
  logic              arc_go;
  logic              start_go;
  logic              k_zero;
  logic              mean_go;
  logic              learn_go;
  logic              corr_go;
  logic              in_window;
  logic [K_W-1:0]    k_next;
  logic [K_W-1:0]    k_less;
  logic [VW-1:0]     target_next;
  logic [MEAN_W:0]   rounded;
  logic [VW:0]       learn_raw;
  logic [VW-1:0]     learned_val;
  logic              err_neg;
  logic [VW-1:0]     err_mag;
  logic [GAIN_W-1:0] gain_mag;
  logic              welding_next;
  logic              probing_next;
  logic              sstop_now;
  logic              pcont_now;

  // serial units
  logic                   mul_start;
  logic [MEAN_W-1:0]      mul_a;
  logic [MB_W-1:0]        mul_b;
  logic                   mul_busy;
  logic [MEAN_W+MB_W-1:0] mul_prod;
  logic                   div_start;
  logic [NUM_W-1:0]       div_num;
  logic [K_W-1:0]         div_den;
  logic                   div_busy;
  logic [MEAN_W-1:0]      div_quot;

  // correction saturation
  logic [VW-1:0]  corr_mag;
  logic [31:0]    corr_mag32;
  steps_t         steps_sat;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign height_on  = height_enable && (weld_mode == MODE_PULSE);

  always_comb begin
    welding_next = welding;
    probing_next = probing;
    sstop_now    = 1'b0;
    pcont_now    = 1'b0;
    sample_live  = (weld_mode != MODE_OFF) && !item.long_move;
    is_contact   = CMP_W'(item.voltage) < CMP_W'(contact_threshold);
    case (item.op)
      OP_SAMPLE: begin
        if (sample_live && is_contact) begin
          pcont_now    = probing;
          probing_next = 1'b0;
          sstop_now    = welding;
          welding_next = 1'b0;
        end
      end
      OP_START: begin
        if (!welding) welding_next = 1'b1;
      end
      OP_PROBE: begin
        if (!welding && height_on) probing_next = 1'b1;
      end
      OP_STOP: begin
        sstop_now    = welding;
        welding_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    arc_go   = (item.op == OP_SAMPLE) && sample_live && !is_contact && welding;
    start_go = (item.op == OP_START) && !welding;
    k_less   = k - K_W'(1);
    k_zero   = (k == '0);
    mean_go  = arc_go && !k_zero && (k <= learn_samples);
    learn_go = arc_go && (k == learn_samples + K_W'(1))
               && (CMP_W'(target) < CMP_W'(ONE_VOLT));

    // mean rounded to Q8.8, half up, saturated
    rounded     = (MEAN_W+1)'(mean) + (MEAN_W+1)'(HALF_LSB);
    learn_raw   = rounded[MEAN_W:FRAC_BITS];
    learned_val = learn_raw[VW] ? {VW{1'b1}} : learn_raw[VW-1:0];

    k_next = k;
    if (start_go) begin
      k_next = '0;
    end else if (arc_go && (k_zero || mean_go || learn_go)) begin
      k_next = k + K_W'(1);
    end

    target_next = target;
    if (start_go) begin
      target_next = (CMP_W'(item.stored_target) >= CMP_W'(ONE_VOLT))
                    ? item.stored_target : '0;
    end else if (learn_go) begin
      target_next = learned_val;
    end

    in_window = (CMP_W'(item.voltage) < CMP_W'(target_next) + CMP_W'(window_above))
             && (CMP_W'(item.voltage) + CMP_W'(window_below) > CMP_W'(target_next));
    corr_go   = arc_go && (target_next != '0) && (k_next >= K_W'(CORR_MIN_K))
             && in_window && height_on;

    err_neg  = item.voltage > target_next;
    err_mag  = err_neg ? (item.voltage - target_next) : (target_next - item.voltage);
    gain_mag = height_gain[GAIN_W-1] ? (GAIN_W'(0) - height_gain) : height_gain;
  end

  // multiplier runs the correction first, then mean * count
  always_comb begin
    if (state == S_IDLE) begin
      if (corr_go) begin
        mul_a = MEAN_W'(err_mag);
        mul_b = MB_W'(gain_mag);
      end else begin
        mul_a = mean;
        mul_b = MB_W'(k_less[CW-1:0]);
      end
    end else begin
      mul_a = mean;
      mul_b = MB_W'(c_hold);
    end
    mul_start = (accept && (corr_go || mean_go))
             || ((state == S_CMUL) && !mul_busy && mean_pend);
  end

  avhc_mul #(
    .A_W(MEAN_W),
    .B_W(MB_W)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .busy   (mul_busy),
    .product(mul_prod)
  );

  assign div_start = (state == S_MMUL) && !mul_busy;
  assign div_num   = NUM_W'(mul_prod[MEAN_W+CW-1:0])
                   + NUM_W'({v_hold, {FRAC_BITS{1'b0}}});
  assign div_den   = K_W'(c_hold) + K_W'(1);

  avhc_div #(
    .Q_W(MEAN_W),
    .D_W(K_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quot (div_quot)
  );

  // whole steps, truncated toward zero, clipped to the signed step range
  always_comb begin
    corr_mag   = mul_prod[VW+GAIN_FRAC-1:GAIN_FRAC];
    corr_mag32 = 32'(corr_mag);
    if (corr_neg) begin
      steps_sat = (corr_mag32 >= 32'(STEP_NEG_MAX)) ? steps_t'(STEP_NEG_MAX)
                                                   : steps_t'(32'd0 - corr_mag32);
    end else begin
      steps_sat = (corr_mag32 > 32'(STEP_POS_MAX)) ? steps_t'(STEP_POS_MAX)
                                                  : steps_t'(corr_mag32);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weld_mode         <= MODE_OFF;
      height_enable     <= 1'b0;
      contact_threshold <= EXT_W'(RST_CONTACT);
      learn_samples     <= K_W'(RST_LEARN);
      window_above      <= EXT_W'(RST_WINDOW);
      window_below      <= EXT_W'(RST_WINDOW);
      height_gain       <= RST_GAIN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WELD_MODE:     weld_mode         <= cfg_data[MODE_W-1:0];
        REG_HEIGHT_ENABLE: height_enable     <= cfg_data[0];
        REG_CONTACT_THR:   contact_threshold <= EXT_W'(cfg_data[VW-1:0]);
        REG_LEARN_SAMPLES: learn_samples     <= K_W'(cfg_data[CW-1:0]);
        REG_WINDOW_ABOVE:  window_above      <= EXT_W'(cfg_data[VW-1:0]);
        REG_WINDOW_BELOW:  window_below      <= EXT_W'(cfg_data[VW-1:0]);
        REG_HEIGHT_GAIN:   height_gain       <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      welding      <= 1'b0;
      probing      <= 1'b0;
      k            <= '0;
      mean         <= '0;
      target       <= '0;
      state        <= S_IDLE;
      result.valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            welding <= welding_next;
            probing <= probing_next;
            k       <= k_next;
            target  <= target_next;
            if (start_go) mean <= '0;
            if (corr_go) begin
              state <= S_CMUL;
            end else if (mean_go) begin
              state <= S_MMUL;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CMUL: begin
          if (!mul_busy) state <= mean_pend ? S_MMUL : S_DONE;
        end
        S_MMUL: begin
          if (!mul_busy) state <= S_DIV;
        end
        S_DIV: begin
          if (!div_busy) begin
            mean  <= div_quot;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if ((state == S_DONE) && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  // request data held while the serial units work
  always_ff @(posedge clk) begin
    if (accept) begin
      mean_pend   <= mean_go;
      corr_neg    <= err_neg ^ height_gain[GAIN_W-1];
      c_hold      <= k_less[CW-1:0];
      v_hold      <= item.voltage;
      res_arc     <= arc_go;
      res_sstop   <= sstop_now;
      res_pcont   <= pcont_now;
      res_mvalid  <= corr_go;
      res_steps   <= '0;
      res_learned <= learn_go;
      res_target  <= target_next;
    end else if ((state == S_CMUL) && !mul_busy) begin
      res_steps <= steps_sat;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!result.valid || result.ready)) begin
      result.arc_present    <= res_arc;
      result.short_stop     <= res_sstop;
      result.probe_contact  <= res_pcont;
      result.move_valid     <= res_mvalid;
      result.move_steps     <= res_steps;
      result.target_learned <= res_learned;
      result.target_now     <= res_target;
    end
  end

  // one request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item.ready)
    else $error("request accepted while another is in flight");

  // divider is only started once the product has settled
  a_div_after_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !mul_busy)
    else $error("divider running with multiplier busy");

  a_steps_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.move_valid) |-> (result.move_steps == '0))
    else $error("step count without a move");

  a_arc_not_stop: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.arc_present) |-> !result.short_stop)
    else $error("arc present and weld stopped in one result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside the completion state");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking bench for the arc voltage height controller core
`timescale 1ns / 1ps

module tb_top;
  import avhc_pkg::*;

  localparam cfg_index_t REG_UNUSED  = 3'd7;
  localparam weld_mode_t MODE_REMOTE = 2'd2;
  // spare code, runs like an enabled mode without height control
  localparam weld_mode_t MODE_SPARE  = 2'd3;

  typedef struct {
    logic        arc_present;
    logic        short_stop;
    logic        probe_contact;
    logic        move_valid;
    logic [15:0] move_steps;
    logic        target_learned;
    logic [15:0] target_now;
  } status_t;

  // mirrors the controller: config copy, weld/probe state and learned target
  class height_ctrl_scoreboard;
    weld_mode_t  weld_mode;
    logic        height_en;
    longint      contact_thr;
    longint      learn_count;
    longint      win_above;
    longint      win_below;
    longint      gain;
    bit          welding;
    bit          probing;
    bit          probe_done;
    longint      sample_count;
    longint      running_mean;
    longint      target_volts;
    status_t     pending_status[$];
    int          mismatches;
    int          results_seen;

    function new();
      weld_mode    = MODE_OFF;
      height_en    = 1'b0;
      contact_thr  = RST_CONTACT;
      learn_count  = RST_LEARN;
      win_above    = RST_WINDOW;
      win_below    = RST_WINDOW;
      gain         = RST_GAIN;
      welding      = 1'b0;
      probing      = 1'b0;
      probe_done   = 1'b1;
      sample_count = -1;
      running_mean = 0;
      target_volts = 0;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [15:0] data);
      logic signed [15:0] g;
      g = data;
      case (idx)
        REG_WELD_MODE:     weld_mode   = data[MODE_W-1:0];
        REG_HEIGHT_ENABLE: height_en   = data[0];
        REG_CONTACT_THR:   contact_thr = data;
        REG_LEARN_SAMPLES: learn_count = data;
        REG_WINDOW_ABOVE:  win_above   = data;
        REG_WINDOW_BELOW:  win_below   = data;
        REG_HEIGHT_GAIN:   gain        = g;
        default: ;
      endcase
    endfunction

    function bit height_on();
      return height_en && weld_mode == MODE_PULSE;
    endfunction

    // gain * (target - v) in Q16.16, truncated toward zero, saturated
    function longint step_correction(longint v);
      longint prod;
      longint mag;
      prod = gain * (target_volts - v);
      mag  = (prod < 0) ? -prod : prod;
      mag  = mag >> GAIN_FRAC;
      if (prod < 0) begin
        if (mag > STEP_NEG_MAX) mag = STEP_NEG_MAX;
        return -mag;
      end
      if (mag > STEP_POS_MAX) mag = STEP_POS_MAX;
      return mag;
    endfunction

    function void note_request(op_code_t op, logic [15:0] v, logic [15:0] st, logic lm);
      status_t r;
      longint  vl;
      longint  t;
      vl = v;
      r  = '{default: '0};
      case (op)
        OP_SAMPLE: begin
          if (weld_mode != MODE_OFF && !lm) begin
            if (vl < contact_thr) begin
              if (probing) begin
                probing         = 1'b0;
                probe_done      = 1'b1;
                r.probe_contact = 1'b1;
              end
              if (welding) begin
                welding      = 1'b0;
                r.short_stop = 1'b1;
                if (height_on()) probe_done = 1'b0;
              end
            end else if (welding) begin
              r.arc_present = 1'b1;
              if (sample_count < 0) begin
                // first sample after start is dropped
                sample_count++;
              end else if (sample_count < learn_count) begin
                running_mean = (running_mean * sample_count + (vl << FRAC_BITS)) /
                               (sample_count + 1);
                sample_count++;
              end else if (sample_count == learn_count && target_volts < ONE_VOLT) begin
                t = (running_mean + HALF_LSB) >> FRAC_BITS;
                if (t > 65535) t = 65535;
                target_volts     = t;
                r.target_learned = 1'b1;
                sample_count++;
              end
              if (target_volts > 0 && sample_count > 1 && height_on() &&
                  vl < target_volts + win_above && vl > target_volts - win_below) begin
                r.move_valid = 1'b1;
                r.move_steps = 16'(step_correction(vl));
              end
            end
          end
        end
        OP_START: begin
          if (!welding) begin
            target_volts = (st < ONE_VOLT) ? 0 : longint'(st);
            sample_count = -1;
            running_mean = 0;
            welding      = 1'b1;
          end
        end
        OP_PROBE: begin
          if (!welding && height_on()) begin
            probing    = 1'b1;
            probe_done = 1'b0;
          end
        end
        default: begin
          if (welding) r.short_stop = 1'b1;
          welding = 1'b0;
        end
      endcase
      r.target_now = 16'(target_volts);
      pending_status.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(status_t got);
      status_t want;
      results_seen++;
      if (pending_status.size() == 0) begin
        $error("result arrived with no request waiting");
        mismatches++;
        return;
      end
      want = pending_status.pop_front();
      compare_field("arc_present", want.arc_present, got.arc_present);
      compare_field("short_stop", want.short_stop, got.short_stop);
      compare_field("probe_contact", want.probe_contact, got.probe_contact);
      compare_field("move_valid", want.move_valid, got.move_valid);
      compare_field("move_steps", want.move_steps, got.move_steps);
      compare_field("target_learned", want.target_learned, got.target_learned);
      compare_field("target_now", want.target_now, got.target_now);
    endfunction

    function int pending();
      return pending_status.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  cfg_index_t  cfg_index;
  logic [15:0] cfg_data;

  avhc_in_if  #(.VOLTAGE_WIDTH(16)) item_ch ();
  avhc_out_if #(.VOLTAGE_WIDTH(16)) result_ch ();

  arc_voltage_height_control_core #(
    .VOLTAGE_WIDTH(16),
    .COUNT_WIDTH(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  height_ctrl_scoreboard sb;
  bit no_idle;
  bit hold_off;
  int requests_sent;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  task automatic send_item(op_code_t op, logic [15:0] v, logic [15:0] st, logic lm);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid         = 1'b1;
    item_ch.op            = op;
    item_ch.voltage       = v;
    item_ch.stored_target = st;
    item_ch.long_move     = lm;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_request(op, v, st, lm);
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [15:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] mode, logic [15:0] en, logic [15:0] thr,
                                logic [15:0] learn, logic [15:0] above,
                                logic [15:0] below, logic [15:0] g);
    wait_idle();
    write_reg(REG_WELD_MODE, mode);
    write_reg(REG_HEIGHT_ENABLE, en);
    write_reg(REG_CONTACT_THR, thr);
    write_reg(REG_LEARN_SAMPLES, learn);
    write_reg(REG_WINDOW_ABOVE, above);
    write_reg(REG_WINDOW_BELOW, below);
    write_reg(REG_HEIGHT_GAIN, g);
    settings_used++;
  endtask

  // mostly start / samples / stop sequences around a per-weld base voltage
  task automatic run_random(int quota);
    int          sent;
    int          len;
    int          base;
    int          vv;
    int          thr;
    logic [15:0] st;
    sent = 0;
    while (sent < quota) begin
      no_idle = ($urandom_range(0, 4) == 0);
      thr     = int'(sb.contact_thr);
      if ($urandom_range(0, 19) == 0) wait_idle();
      if ($urandom_range(0, 9) == 0) begin
        send_item(op_code_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  1'($urandom));
        sent++;
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(OP_PROBE, 16'($urandom), 16'($urandom), 1'b0);
          vv = (thr > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, thr - 1)
                                                      : $urandom_range(0, 65535);
          send_item(OP_SAMPLE, 16'(vv), 16'($urandom), 1'b0);
          sent += 2;
        end
        st = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
        send_item(OP_START, 16'($urandom), st, 1'($urandom));
        sent++;
        if (thr < 'h3000 && $urandom_range(0, 1) == 0) base = $urandom_range(thr, 'h3000);
        else base = $urandom_range(thr, 65535);
        len = $urandom_range(2, 24);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 19))
            0, 1: vv = $urandom_range(0, 65535);
            2: vv = (thr > 0) ? $urandom_range(0, thr - 1) : 0;
            default: begin
              vv = base - 'h300 + int'($urandom_range(0, 'h600));
              if (vv < thr) vv = thr;
              if (vv > 65535) vv = 65535;
            end
          endcase
          send_item(OP_SAMPLE, 16'(vv), 16'($urandom), ($urandom_range(0, 9) == 0));
          sent++;
        end
        if ($urandom_range(0, 3) != 0) begin
          send_item(OP_STOP, 16'($urandom), 16'($urandom), 1'($urandom));
          sent++;
        end
      end
    end
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int      stall;
    status_t got;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_off) begin
        @(negedge clk);
        result_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      got.arc_present    = result_ch.arc_present;
      got.short_stop     = result_ch.short_stop;
      got.probe_contact  = result_ch.probe_contact;
      got.move_valid     = result_ch.move_valid;
      got.move_steps     = result_ch.move_steps;
      got.target_learned = result_ch.target_learned;
      got.target_now     = result_ch.target_now;
      sb.check_result(got);
    end
  end

  initial begin
    int idle_wait;
    sb                    = new();
    no_idle               = 1'b0;
    hold_off              = 1'b0;
    requests_sent         = 0;
    settings_used         = 0;
    rst                   = 1'b1;
    cfg_wr_en             = 1'b0;
    cfg_index             = REG_WELD_MODE;
    cfg_data              = '0;
    item_ch.valid         = 1'b0;
    item_ch.op            = OP_SAMPLE;
    item_ch.voltage       = '0;
    item_ch.stored_target = '0;
    item_ch.long_move     = 1'b0;
    result_ch.ready       = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: remaining registers keep their reset values
    write_reg(REG_WELD_MODE, 16'(MODE_PULSE));
    write_reg(REG_HEIGHT_ENABLE, 16'd1);
    write_reg(REG_LEARN_SAMPLES, 16'd2);
    write_reg(REG_UNUSED, 16'hFFFF);
    settings_used++;
    send_item(OP_PROBE, 16'h0000, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h0010, 16'h0000, 1'b0);   // probe touches work
    send_item(OP_STOP, 16'h0000, 16'h0000, 1'b0);     // stop while idle
    send_item(OP_START, 16'h0000, 16'h0000, 1'b0);
    send_item(OP_START, 16'h0000, 16'h1234, 1'b0);    // ignored while welding
    send_item(OP_PROBE, 16'h0000, 16'h0000, 1'b0);    // ignored while welding
    send_item(OP_SAMPLE, 16'h0A00, 16'h0000, 1'b1);   // long traverse
    send_item(OP_SAMPLE, 16'h0A00, 16'h0000, 1'b0);   // dropped
    send_item(OP_SAMPLE, 16'h0A00, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h0B00, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h0A80, 16'h0000, 1'b0);   // learns target
    send_item(OP_SAMPLE, 16'hFFFF, 16'h0000, 1'b0);   // outside window
    send_item(OP_SAMPLE, 16'h0900, 16'h0000, 1'b0);
    send_item(OP_STOP, 16'h0000, 16'h0000, 1'b0);
    send_item(OP_START, 16'hFFFF, 16'hFFFF, 1'b0);
    send_item(OP_SAMPLE, 16'hFFFF, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'hFFFF, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'hFF00, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'hFFF0, 16'h0000, 1'b0);
    send_item(OP_SAMPLE, 16'h0000, 16'hFFFF, 1'b0);   // short stop
    send_item(OP_PROBE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(OP_START, 16'hFFFF, 16'h00FF, 1'b1);    // just under one volt
    send_item(OP_SAMPLE, 16'h0000, 16'h0000, 1'b0);   // probe contact and stop together

    apply_settings(16'(MODE_PULSE), 16'd1, 16'd256, 16'd4, 16'd512, 16'd512, 16'd256);
    run_random(70);
    apply_settings(16'(MODE_REMOTE), 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
    run_random(60);
    apply_settings(16'(MODE_PULSE), 16'd1, 16'd0, 16'd1, 16'hFFFF, 16'hFFFF, 16'h8000);
    hold_off = 1'b1;
    run_random(70);
    apply_settings(16'(MODE_SPARE), 16'd0, 16'hFFFF, 16'd3, 16'd1000, 16'd1000, 16'hFFFF);
    run_random(50);
    apply_settings(16'(MODE_OFF), 16'd1, 16'd300, 16'd2, 16'd512, 16'd512, 16'd256);
    run_random(30);
    apply_settings(16'(MODE_PULSE), 16'd1, 16'd128, 16'hFFFF, 16'd1000, 16'd300, 16'hFF00);
    run_random(70);
    apply_settings(16'(MODE_PULSE), 16'd0, 16'd400, 16'd5, 16'h2000, 16'h2000, 16'd512);
    run_random(50);
    apply_settings(16'(MODE_PULSE), 16'd1, 16'd512, 16'd0, 16'h0800, 16'h0100, 16'h0400);
    run_random(70);

    wait_idle();
    idle_wait = 0;
    while (idle_wait < 200) begin
      @(posedge clk);
      idle_wait++;
    end
    $display("covered %0d requests and %0d results across %0d register settings",
             requests_sent, sb.results_seen, settings_used);
    $display("events: samples, start, probe, stop; learned and stored targets; stalls");
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      if (sb.pending() != 0) $error("%0d expected results never arrived", sb.pending());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
